/* rtl/bicim_pkg.sv */
// Shared widths, codes and state types of the change interval monitor.
`timescale 1ns / 1ps
`default_nettype none
package bicim_pkg;

   localparam int STATUS_W    = 2;
   localparam int RUN_TICKS_W = 32;
   localparam int INTERVAL_W  = 42;
   localparam int SUM_W       = 46;
   localparam int PERIOD_W    = 10;
   localparam int DEPTH_W     = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int MUL_CNT_W   = $clog2(PERIOD_W);
   localparam int DIV_CNT_W   = $clog2(SUM_W);

   localparam logic [STATUS_W-1:0] STATUS_LOW    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIGH   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FAILED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_DEPTH = 1'b1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;
   localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 5'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RING,
      ST_DIV,
      ST_RESULT
   } mon_state_type;

   typedef enum logic [1:0] {
      RING_IDLE,
      RING_WAIT,
      RING_ADD
   } ring_state_type;

   typedef struct packed {
      logic               done;
      logic [DEPTH_W-1:0] count;
   } ring_sts_type;

endpackage
`default_nettype wire

/* rtl/bicim_req_if.sv */
// Request channel carrying one binary sample and its read status.
`timescale 1ns / 1ps
`default_nettype none
interface bicim_req_if;
   logic valid;
   logic ready;
   logic sample_value;
   logic read_failed;

   modport source (output valid, output sample_value, output read_failed, input ready);
   modport sink (input valid, input sample_value, input read_failed, output ready);
endinterface
`default_nettype wire

/* rtl/bicim_rsp_if.sv */
// Response channel carrying status, run length and interval statistics.
`timescale 1ns / 1ps
`default_nettype none
interface bicim_rsp_if;
   import bicim_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    sensor_status;
   logic [RUN_TICKS_W-1:0] run_ticks;
   logic                   level_changed;
   logic [INTERVAL_W-1:0]  last_interval_ms;
   logic [INTERVAL_W-1:0]  average_interval_ms;
   logic [DEPTH_W-1:0]     intervals_held;

   modport source (
      output valid, output sensor_status, output run_ticks, output level_changed,
      output last_interval_ms, output average_interval_ms, output intervals_held,
      input ready
   );
   modport sink (
      input valid, input sensor_status, input run_ticks, input level_changed,
      input last_interval_ms, input average_interval_ms, input intervals_held,
      output ready
   );
endinterface
`default_nettype wire

/* rtl/binary_input_change_interval_monitor_core.sv */
// Change interval monitor: run counter, interval ring and running average.
// Usage:
//   req_chan takes one sample per update tick with its read-failed flag.
//   rsp_chan returns exactly one response per request: level status, run
//   length in ticks, a level-changed flag, the last interval in ms, the
//   average interval in ms and the number of intervals held.
//   csr_we/csr_index/csr_wdata write the update period (index 0) and the
//   history depth (index 1); write them only while the block is idle.
// Sequencing:
//   One request is in flight at a time. Failed reads, first samples and
//   unchanged levels go from acceptance straight to the response stage.
//   A level change that leaves two or more intervals held runs the
//   bit-serial multiply by the period, the ring sum over the held
//   intervals (one memory read port), the bit-serial divide and then the
//   response stage. With fewer held the divide is skipped.
// Reset:
//   Clears status to failed, the run counter, ring fill and statistics;
//   period returns to 100 ms and depth to 10. Ring contents are not cleared.
// Backpressure:
//   The response register holds while rsp_chan.ready is low; a new request
//   is still accepted and computed, then waits for the register to free.
`timescale 1ns / 1ps
`default_nettype none
module binary_input_change_interval_monitor_core #(
   parameter int MAX_HISTORY = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire [bicim_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [bicim_pkg::PERIOD_W-1:0]      csr_wdata,
   bicim_req_if.sink                          req_chan,
   bicim_rsp_if.source                        rsp_chan
);
   import bicim_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {{(COUNT_WIDTH-1){1'b1}}, 1'b0};

   mon_state_type          state_ff;
   mon_state_type          state_in;
   logic [PERIOD_W-1:0]    period_ff;
   logic [DEPTH_W-1:0]     depth_ff;
   logic                   prev_level_ff;
   logic                   have_sample_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [COUNT_WIDTH-1:0] tick_ff;
   logic                   changed_ff;
   logic [INTERVAL_W-1:0]  last_interval_ff;
   logic [INTERVAL_W-1:0]  average_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [RUN_TICKS_W-1:0] rsp_ticks_ff;
   logic                   rsp_changed_ff;
   logic [INTERVAL_W-1:0]  rsp_last_ff;
   logic [INTERVAL_W-1:0]  rsp_average_ff;
   logic [DEPTH_W-1:0]     rsp_held_ff;

   logic                   req_ready;
   logic                   req_fire;
   logic                   good;
   logic                   change_hit;
   logic                   mul_start;
   logic                   mul_done;
   logic [INTERVAL_W-1:0]  product;
   logic                   ring_start;
   ring_sts_type           ring_sts;
   logic [SUM_W-1:0]       ring_sum;
   logic                   div_start;
   logic                   div_done;
   logic [INTERVAL_W-1:0]  quotient;
   logic                   rsp_load;

   assign req_fire   = req_chan.valid && req_ready;
   assign good       = !req_chan.read_failed;
   assign change_hit = good && have_sample_ff && (req_chan.sample_value != prev_level_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = change_hit ? ST_MUL : ST_RESULT;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_RING;
            end
         end
         ST_RING: begin
            if (ring_sts.done) begin
               state_in = (ring_sts.count > DEPTH_W'(1)) ? ST_DIV : ST_RESULT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      mul_start  = 1'b0;
      ring_start = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            mul_start = req_chan.valid && change_hit;
         end
         ST_MUL: begin
            ring_start = mul_done;
         end
         ST_RING: begin
            div_start = ring_sts.done && (ring_sts.count > DEPTH_W'(1));
         end
         ST_RESULT: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = req_ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         depth_ff  <= DEPTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UPDATE_PERIOD: period_ff <= csr_wdata;
            CSR_HISTORY_DEPTH: depth_ff  <= csr_wdata[DEPTH_W-1:0];
            default: period_ff <= period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         prev_level_ff    <= 1'b0;
         have_sample_ff   <= 1'b0;
         status_ff        <= STATUS_FAILED;
         tick_ff          <= '0;
         changed_ff       <= 1'b0;
         last_interval_ff <= '0;
         average_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            changed_ff <= change_hit;
            if (good) begin
               prev_level_ff  <= req_chan.sample_value;
               have_sample_ff <= 1'b1;
               status_ff      <= req_chan.sample_value ? STATUS_HIGH : STATUS_LOW;
               if (!have_sample_ff || change_hit) begin
                  tick_ff <= '0;
               end else if (tick_ff != COUNT_LIMIT) begin
                  tick_ff <= tick_ff + 1'b1;
               end
            end else begin
               status_ff <= STATUS_FAILED;
            end
         end
         if (ring_start) begin
            last_interval_ff <= product;
         end
         if ((state_ff == ST_DIV) && div_done) begin
            average_ff <= quotient;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_ticks_ff   <= RUN_TICKS_W'(tick_ff);
         rsp_changed_ff <= changed_ff;
         rsp_last_ff    <= last_interval_ff;
         rsp_average_ff <= average_ff;
         rsp_held_ff    <= ring_sts.count;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.sensor_status       = rsp_status_ff;
   assign rsp_chan.run_ticks           = rsp_ticks_ff;
   assign rsp_chan.level_changed       = rsp_changed_ff;
   assign rsp_chan.last_interval_ms    = rsp_last_ff;
   assign rsp_chan.average_interval_ms = rsp_average_ff;
   assign rsp_chan.intervals_held      = rsp_held_ff;

   bicim_mul #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (tick_ff),
      .multiplier   (period_ff),
      .done         (mul_done),
      .product      (product)
   );

   bicim_ring #(
      .MAX_HISTORY (MAX_HISTORY)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .start    (ring_start),
      .interval (product),
      .depth    (depth_ff),
      .sts      (ring_sts),
      .sum      (ring_sum)
   );

   bicim_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ring_sum),
      .divisor  (ring_sts.count),
      .done     (div_done),
      .quotient (quotient)
   );
endmodule
`default_nettype wire

/* rtl/bicim_mul.sv */
// Bit-serial shift-add multiplier: run length times update period.
`timescale 1ns / 1ps
`default_nettype none
module bicim_mul #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire [COUNT_WIDTH-1:0]              multiplicand,
   input  wire [bicim_pkg::PERIOD_W-1:0]      multiplier,
   output logic                               done,
   output logic [bicim_pkg::INTERVAL_W-1:0]   product
);
   import bicim_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [MUL_CNT_W-1:0]  cnt_ff;
   logic [INTERVAL_W-1:0] mcand_ff;
   logic [PERIOD_W-1:0]   mplier_ff;
   logic [INTERVAL_W-1:0] acc_ff;
   logic                  last_step;

   assign last_step = (cnt_ff == MUL_CNT_W'(PERIOD_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff    <= '0;
         mcand_ff  <= INTERVAL_W'(multiplicand);
         mplier_ff <= multiplier;
         acc_ff    <= '0;
      end else if (busy_ff) begin
         cnt_ff    <= cnt_ff + 1'b1;
         mcand_ff  <= {mcand_ff[INTERVAL_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[PERIOD_W-1:1]};
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

/* rtl/bicim_div.sv */
// Bit-serial restoring divider: interval sum over ring fill.
`timescale 1ns / 1ps
`default_nettype none
module bicim_div (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire [bicim_pkg::SUM_W-1:0]         dividend,
   input  wire [bicim_pkg::DEPTH_W-1:0]       divisor,
   output logic                               done,
   output logic [bicim_pkg::INTERVAL_W-1:0]   quotient
);
   import bicim_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [DEPTH_W-1:0]   rem_ff;
   logic [DEPTH_W-1:0]   div_ff;
   logic [DEPTH_W:0]     trial;
   logic [DEPTH_W:0]     diff;
   logic                 fits;
   logic                 last_step;

   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign diff      = trial - {1'b0, div_ff};
   assign fits      = (trial >= {1'b0, div_ff});
   assign last_step = (cnt_ff == DIV_CNT_W'(SUM_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
         rem_ff <= fits ? diff[DEPTH_W-1:0] : trial[DEPTH_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[INTERVAL_W-1:0];
endmodule
`default_nettype wire

/* rtl/bicim_ring.sv */
// Interval ring: push the newest interval and sum the held entries serially.
`timescale 1ns / 1ps
`default_nettype none
module bicim_ring #(
   parameter int MAX_HISTORY = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire [bicim_pkg::INTERVAL_W-1:0]    interval,
   input  wire [bicim_pkg::DEPTH_W-1:0]       depth,
   output bicim_pkg::ring_sts_type            sts,
   output logic [bicim_pkg::SUM_W-1:0]        sum
);
   import bicim_pkg::*;

   localparam int IDX_W = $clog2(MAX_HISTORY);
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_HISTORY - 1);
   localparam logic [DEPTH_W-1:0] MAX_DEPTH =
      DEPTH_W'((MAX_HISTORY > 31) ? 31 : MAX_HISTORY);

   ring_state_type        state_ff;
   ring_state_type        state_in;
   logic [IDX_W-1:0]      head_ff;
   logic [IDX_W-1:0]      head_in;
   logic [DEPTH_W-1:0]    count_ff;
   logic [DEPTH_W-1:0]    count_in;
   logic [DEPTH_W-1:0]    remain_ff;
   logic [IDX_W-1:0]      rd_addr_ff;
   logic [INTERVAL_W-1:0] rd_data_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic                  done_ff;
   logic [DEPTH_W-1:0]    depth_eff;
   logic [DEPTH_W:0]      count_inc;
   logic                  push_en;
   logic                  add_en;
   logic                  last_add;

   logic [INTERVAL_W-1:0] ring_mem [MAX_HISTORY];

   assign depth_eff = (depth > MAX_DEPTH) ? MAX_DEPTH : depth;
   assign count_inc = {1'b0, count_ff} + 1'b1;
   assign count_in  = (count_inc > {1'b0, depth_eff}) ? depth_eff : count_inc[DEPTH_W-1:0];
   assign head_in   = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RING_IDLE: begin
            if (push_en && (count_in > DEPTH_W'(1))) begin
               state_in = RING_WAIT;
            end
         end
         RING_WAIT: begin
            state_in = RING_ADD;
         end
         RING_ADD: begin
            if (last_add) begin
               state_in = RING_IDLE;
            end else begin
               state_in = RING_WAIT;
            end
         end
         default: begin
            state_in = RING_IDLE;
         end
      endcase
   end

   always_comb begin
      push_en  = 1'b0;
      add_en   = 1'b0;
      last_add = 1'b0;
      case (state_ff)
         RING_IDLE: begin
            push_en = start;
         end
         RING_ADD: begin
            add_en   = 1'b1;
            last_add = (remain_ff == DEPTH_W'(1));
         end
         default: begin
            push_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RING_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (push_en && (count_in <= DEPTH_W'(1))) || last_add;
         if (push_en) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         rd_addr_ff <= head_in;
         sum_ff     <= '0;
         remain_ff  <= count_in;
      end else if (add_en) begin
         sum_ff     <= sum_ff + SUM_W'(rd_data_ff);
         remain_ff  <= remain_ff - 1'b1;
         rd_addr_ff <= (rd_addr_ff == '0) ? LAST_IDX : rd_addr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         ring_mem[head_in] <= interval;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[rd_addr_ff];
   end

   assign sts.done  = done_ff;
   assign sts.count = count_ff;
   assign sum       = sum_ff;
endmodule
`default_nettype wire

/* bench/bicim_monitor_checker.sv */
// Passive checker: predicts every monitor response and compares it with the block.
`timescale 1ns / 1ps
module bicim_monitor_checker
   import bicim_pkg::*;
#(
   parameter int MAX_HISTORY = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PERIOD_W-1:0]  csr_wdata,
   bicim_req_if                 req_mon,
   bicim_rsp_if                 rsp_mon,
   output int                   mismatches,
   output int                   awaited,
   output int                   responses_seen,
   output int                   level_changes
);

   localparam logic [RUN_TICKS_W-1:0] TICK_CEILING =
      RUN_TICKS_W'((64'd1 << COUNT_WIDTH) - 64'd2);

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [RUN_TICKS_W-1:0] ticks;
      logic                   changed;
      logic [INTERVAL_W-1:0]  last_ms;
      logic [INTERVAL_W-1:0]  avg_ms;
      logic [DEPTH_W-1:0]     held;
   } monitor_report_t;

   monitor_report_t awaited_reports[$];

   logic [PERIOD_W-1:0]    period_ms;
   logic [DEPTH_W-1:0]     depth_cfg;
   logic                   prev_level;
   logic                   started;
   logic [STATUS_W-1:0]    status_now;
   logic [RUN_TICKS_W-1:0] run_count;
   logic [INTERVAL_W-1:0]  interval_ring [MAX_HISTORY];
   int                     ring_head;
   int                     ring_fill;
   logic [SUM_W-1:0]       ring_sum;
   logic [INTERVAL_W-1:0]  mean_ms;
   logic [INTERVAL_W-1:0]  last_ms;

   initial begin
      mismatches = 0;
      awaited = 0;
      responses_seen = 0;
      level_changes = 0;
   end

   task automatic clear_monitor();
      period_ms = PERIOD_RESET;
      depth_cfg = DEPTH_RESET;
      prev_level = 1'b0;
      started = 1'b0;
      status_now = STATUS_FAILED;
      run_count = '0;
      ring_head = 0;
      ring_fill = 0;
      ring_sum = '0;
      mean_ms = '0;
      last_ms = '0;
   endtask

   task automatic record_interval(input logic [INTERVAL_W-1:0] ms);
      int limit;
      int pos;
      logic [SUM_W-1:0] acc;
      limit = (depth_cfg > MAX_HISTORY) ? MAX_HISTORY : int'(depth_cfg);
      ring_head = (ring_head + 1) % MAX_HISTORY;
      interval_ring[ring_head] = ms;
      ring_fill = (ring_fill + 1 > limit) ? limit : ring_fill + 1;
      if (ring_fill > 1) begin
         acc = '0;
         pos = ring_head;
         for (int i = 0; i < ring_fill; i++) begin
            acc = acc + SUM_W'(interval_ring[pos]);
            pos = (pos + MAX_HISTORY - 1) % MAX_HISTORY;
         end
         ring_sum = acc;
         mean_ms = INTERVAL_W'(acc / SUM_W'(ring_fill));
      end
   endtask

   task automatic step_monitor(input logic level, input logic failed,
                               output monitor_report_t rep);
      logic changed;
      changed = 1'b0;
      if (failed) begin
         status_now = STATUS_FAILED;
      end else begin
         status_now = level ? STATUS_HIGH : STATUS_LOW;
         if (!started) begin
            started = 1'b1;
            run_count = '0;
         end else if (level == prev_level) begin
            if (run_count < TICK_CEILING) run_count = run_count + 1'b1;
         end else begin
            changed = 1'b1;
            last_ms = INTERVAL_W'(run_count) * INTERVAL_W'(period_ms);
            run_count = '0;
            record_interval(last_ms);
            level_changes++;
         end
         prev_level = level;
      end
      rep.status = status_now;
      rep.ticks = run_count;
      rep.changed = changed;
      rep.last_ms = last_ms;
      rep.avg_ms = mean_ms;
      rep.held = DEPTH_W'(ring_fill);
   endtask

   task automatic show_report(input string tag, input monitor_report_t r);
      $display("  %s status=%0d ticks=%0d changed=%0b last=%0d avg=%0d held=%0d",
               tag, r.status, r.ticks, r.changed, r.last_ms, r.avg_ms, r.held);
   endtask

   always @(posedge clock) begin : track
      monitor_report_t seen;
      monitor_report_t due;
      if (reset) begin
         clear_monitor();
         awaited_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_UPDATE_PERIOD: period_ms = csr_wdata;
               CSR_HISTORY_DEPTH: depth_cfg = csr_wdata[DEPTH_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            step_monitor(req_mon.sample_value, req_mon.read_failed, due);
            awaited_reports.push_back(due);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.status = rsp_mon.sensor_status;
            seen.ticks = rsp_mon.run_ticks;
            seen.changed = rsp_mon.level_changed;
            seen.last_ms = rsp_mon.last_interval_ms;
            seen.avg_ms = rsp_mon.average_interval_ms;
            seen.held = rsp_mon.intervals_held;
            responses_seen++;
            if (awaited_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: response with no request outstanding", $realtime);
                  show_report("got", seen);
               end
            end else begin
               due = awaited_reports.pop_front();
               if (seen.status !== due.status || seen.ticks !== due.ticks ||
                   seen.changed !== due.changed || seen.last_ms !== due.last_ms ||
                   seen.avg_ms !== due.avg_ms || seen.held !== due.held) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: response %0d differs", $realtime, responses_seen);
                     show_report("exp", due);
                     show_report("got", seen);
                  end
               end
            end
         end
      end
      awaited = awaited_reports.size();
   end

endmodule

/* bench/tb_binary_input_change_interval_monitor_core.sv */
// Top of the change interval monitor bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_binary_input_change_interval_monitor_core;
   import bicim_pkg::*;

   localparam int RING_SLOTS  = 16;
   localparam int TICK_W      = 32;
   localparam int ITEM_TARGET = 1500;
   localparam int IDLE_PCT    = 37;
   localparam int PHASE_ITEMS = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int END_PAUSE   = 150;
   localparam int STALL_LIMIT = 5000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_UPDATE_PERIOD;
   logic [PERIOD_W-1:0]  csr_wdata = '0;

   bit steady = 1'b0;
   int holdoffs_asked = 0;
   int holdoffs_done = 0;
   int items_sent = 0;
   int settings_used = 0;

   int mismatches;
   int awaited;
   int responses_seen;
   int level_changes;

   bicim_req_if req_chan ();
   bicim_rsp_if rsp_chan ();

   binary_input_change_interval_monitor_core #(
      .MAX_HISTORY(RING_SLOTS),
      .COUNT_WIDTH(TICK_W)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bicim_monitor_checker #(
      .MAX_HISTORY(RING_SLOTS),
      .COUNT_WIDTH(TICK_W)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .mismatches    (mismatches),
      .awaited       (awaited),
      .responses_seen(responses_seen),
      .level_changes (level_changes)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin : receiver
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoffs_done != holdoffs_asked) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holdoffs_done++;
         end
         rsp_chan.ready = steady || ($urandom_range(99, 0) >= IDLE_PCT);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no request or response moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic offer_sample(input logic level, input logic failed);
      if (!steady) begin
         while ($urandom_range(99, 0) < IDLE_PCT) begin
            req_chan.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid = 1'b1;
      req_chan.sample_value = level;
      req_chan.read_failed = failed;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic emit_run(input logic level, input int len);
      repeat (len) begin
         if ($urandom_range(99, 0) < 8) offer_sample(1'($urandom_range(1, 0)), 1'b1);
         offer_sample(level, 1'b0);
      end
   endtask

   task automatic drain_pipeline();
      req_chan.valid = 1'b0;
      while (awaited != 0) @(negedge clock);
   endtask

   task automatic load_settings(input logic [PERIOD_W-1:0] period,
                                input logic [DEPTH_W-1:0] depth);
      drain_pipeline();
      csr_we = 1'b1;
      csr_index = CSR_UPDATE_PERIOD;
      csr_wdata = period;
      @(negedge clock);
      csr_index = CSR_HISTORY_DEPTH;
      csr_wdata = {5'($urandom_range(31, 0)), depth};
      @(negedge clock);
      csr_we = 1'b0;
      settings_used++;
   endtask

   function automatic logic [PERIOD_W-1:0] pick_period();
      case ($urandom_range(5, 0))
         0: return '0;
         1: return PERIOD_W'(1);
         2: return '1;
         3: return PERIOD_W'(1000);
         default: return PERIOD_W'($urandom_range(1023, 0));
      endcase
   endfunction

   function automatic logic [DEPTH_W-1:0] pick_depth();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return DEPTH_W'(1);
         2: return DEPTH_W'(2);
         3: return DEPTH_W'(16);
         4: return '1;
         5: return DEPTH_W'(17);
         default: return DEPTH_W'($urandom_range(31, 0));
      endcase
   endfunction

   function automatic int pick_run_length();
      int r;
      r = $urandom_range(99, 0);
      if (r < 80) return $urandom_range(4, 1);
      if (r < 97) return $urandom_range(30, 5);
      return $urandom_range(260, 31);
   endfunction

   initial begin : stimulus
      logic level;
      int phase_start;
      req_chan.valid = 1'b0;
      req_chan.sample_value = 1'b0;
      req_chan.read_failed = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      offer_sample(1'b1, 1'b1);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b1);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b0);

      load_settings('1, '1);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b1, 1'b0);

      load_settings('0, DEPTH_W'(1));
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b1, 1'b0);

      load_settings(PERIOD_W'(1), '0);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b0);

      load_settings(PERIOD_W'(1000), DEPTH_W'(16));
      for (int i = 0; i < 5; i++) begin
         offer_sample(1'b1, 1'b0);
         offer_sample(1'b0, 1'b0);
      end
      // shrink the ring below its fill
      load_settings(PERIOD_W'(1000), DEPTH_W'(2));
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b0);
      level = 1'b0;

      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         load_settings(pick_period(), pick_depth());
         steady = (phase == 2);
         if (phase == 1) holdoffs_asked++;
         phase_start = items_sent;
         if (phase == 3) begin
            level = ~level;
            emit_run(level, 300);
         end
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(9, 0) != 0) level = ~level;
            emit_run(level, pick_run_length());
         end
      end
      steady = 1'b0;

      drain_pipeline();
      repeat (END_PAUSE) @(posedge clock);
      $display("Sent %0d samples and checked %0d responses, %0d of them level changes.",
               items_sent, responses_seen, level_changes);
      $display("Register settings: %0d, incl. period 0/1023, depth 0/1/16/31; %0d hold-off(s).",
               settings_used, holdoffs_done);
      if (mismatches == 0 && awaited == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
